// File: rtl/core/reader_response_frame_deframer_top_macros.svh
// Assertion macros shared by the response frame deframer RTL.
// Each macro expands to one labeled concurrent assertion clocked by clk and
// disabled while rst is high; the including module must declare both.
`ifndef READER_RESPONSE_FRAME_DEFRAMER_TOP_MACROS_SVH
`define READER_RESPONSE_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication.
`define RRFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle.
`define RRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rrfd_pkg.sv
// Shared types and constants for the reader response frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rrfd_pkg;

  // Configuration port geometry.
  localparam int AddrW = 3;
  localparam int DataW = 32;

  // Register word indexes.
  localparam logic RegExpectedCommand = 1'b0;

  // Frame constants.
  localparam logic [7:0] PreambleLo  = 8'h00;
  localparam logic [7:0] PreambleHi  = 8'hFF;
  localparam logic [7:0] DirToHost   = 8'hD5;
  localparam logic [7:0] AckLcs      = 8'hFF;
  localparam logic [7:0] NackLen     = 8'hFF;
  localparam logic [7:0] ZeroByte    = 8'h00;

  // End-of-frame status codes.
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_ACK       = 4'd1,
    ST_NACK      = 4'd2,
    ST_PREAMBLE  = 4'd3,
    ST_LEN_CHECK = 4'd4,
    ST_DATA_SUM  = 4'd5,
    ST_POSTAMBLE = 4'd6,
    ST_MISMATCH  = 4'd7,
    ST_TOO_SHORT = 4'd8
  } status_t;

  // Parser phases, one-hot.
  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_PRE      = 11'b000_0000_0010,
    PH_LEN      = 11'b000_0000_0100,
    PH_LCS      = 11'b000_0000_1000,
    PH_ACKPOST  = 11'b000_0001_0000,
    PH_NACKPOST = 11'b000_0010_0000,
    PH_TFI      = 11'b000_0100_0000,
    PH_CMD      = 11'b000_1000_0000,
    PH_DATA     = 11'b001_0000_0000,
    PH_DCS      = 11'b010_0000_0000,
    PH_POST     = 11'b100_0000_0000
  } phase_t;

  // One received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  // One result: payload byte or end-of-frame status.
  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic       last_payload;
    logic [3:0] frame_status;
  } out_t;

endpackage

// File: rtl/core/rrfd_regs.sv
// APB-style configuration register file of the deframer.
// Depends on rrfd_pkg for the address width and register indexes.
`timescale 1ns / 1ps

module rrfd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rrfd_pkg::AddrW-1:0] paddr,
  input  logic [rrfd_pkg::DataW-1:0] pwdata,
  output logic [rrfd_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output logic [7:0]                 expected_command
);
  import rrfd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Command register; the word index is the address above the byte lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= 8'h00;
    end else if (wr_en && (paddr[AddrW-1] == RegExpectedCommand)) begin
      expected_command <= pwdata[7:0];
    end
  end

  // Read back.
  always_comb begin
    if (paddr[AddrW-1] == RegExpectedCommand) begin
      prdata = {{(DataW-8){1'b0}}, expected_command};
    end else begin
      prdata = '0;
    end
  end

endmodule

// File: rtl/core/rrfd_parser.sv
// Frame parser state machine: one byte per unstalled cycle, at most one result.
// Depends on rrfd_pkg and the assertion macro header.
`timescale 1ns / 1ps

module rrfd_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     expected_command,
  input  logic           in_fire,
  input  rrfd_pkg::in_t  in_item,
  output logic           res_valid,
  output rrfd_pkg::out_t res
);
  import rrfd_pkg::*;
  `include "reader_response_frame_deframer_top_macros.svh"

  phase_t     phase, phase_next, cur_phase;
  logic [8:0] byte_position, byte_position_next, cur_pos;
  logic [7:0] data_sum, data_sum_next, cur_sum, sum_add;
  logic [7:0] length_byte, length_byte_next, cur_len;
  logic       frame_empty, frame_empty_next, cur_empty;
  logic [7:0] b;
  logic [7:0] pre_expect;
  logic       last_data;

  assign b = in_item.rx_byte;

  // A frame start restarts the parser before the byte is interpreted.
  always_comb begin
    if (in_item.frame_start) begin
      cur_phase = PH_PRE;
      cur_pos   = 9'd0;
      cur_sum   = 8'd0;
      cur_len   = 8'd0;
      cur_empty = 1'b0;
    end else begin
      cur_phase = phase;
      cur_pos   = byte_position;
      cur_sum   = data_sum;
      cur_len   = length_byte;
      cur_empty = frame_empty;
    end
  end

  assign pre_expect = (cur_pos[1:0] == 2'd2) ? PreambleHi : PreambleLo;
  assign sum_add    = cur_sum + b;
  assign last_data  = (cur_pos == ({1'b0, cur_len} + 9'd4));

  // Next state and result for the current byte.
  always_comb begin
    phase_next         = cur_phase;
    byte_position_next = cur_pos + 9'd1;
    data_sum_next      = cur_sum;
    length_byte_next   = cur_len;
    frame_empty_next   = cur_empty;
    res_valid          = 1'b0;
    res                = '0;
    case (cur_phase)
      PH_PRE: begin
        if ((cur_pos > 9'd2) || (b != pre_expect)) begin
          res_valid = 1'b1;
        res.is_status = 1'b1;
          res.frame_status = ST_PREAMBLE;
        end else if (cur_pos[1:0] == 2'd2) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        length_byte_next = b;
        phase_next       = PH_LCS;
      end
      PH_LCS: begin
        if ((cur_len == ZeroByte) && (b == AckLcs)) begin
          phase_next = PH_ACKPOST;
        end else if ((cur_len == NackLen) && (b == ZeroByte)) begin
          phase_next = PH_NACKPOST;
        end else if ((cur_len + b) != 8'd0) begin
          res_valid        = 1'b1;
          res.is_status    = 1'b1;
          res.frame_status = ST_LEN_CHECK;
        end else if (cur_len < 8'd2) begin
          res_valid        = 1'b1;
          res.is_status    = 1'b1;
          res.frame_status = ST_TOO_SHORT;
        end else begin
          frame_empty_next = (cur_len == 8'd2);
          phase_next       = PH_TFI;
        end
      end
      PH_ACKPOST: begin
        res_valid        = 1'b1;
        res.is_status    = 1'b1;
        res.frame_status = (b == ZeroByte) ? ST_ACK : ST_POSTAMBLE;
      end
      PH_NACKPOST: begin
        res_valid        = 1'b1;
        res.is_status    = 1'b1;
        res.frame_status = (b == ZeroByte) ? ST_NACK : ST_POSTAMBLE;
      end
      PH_TFI: begin
        if (b != DirToHost) begin
          res_valid        = 1'b1;
          res.is_status    = 1'b1;
          res.frame_status = ST_MISMATCH;
        end else begin
          data_sum_next = b;
          phase_next    = PH_CMD;
        end
      end
      PH_CMD: begin
        if (b != (expected_command + 8'd1)) begin
          res_valid        = 1'b1;
          res.is_status    = 1'b1;
          res.frame_status = ST_MISMATCH;
        end else begin
          data_sum_next = sum_add;
          phase_next    = cur_empty ? PH_DCS : PH_DATA;
        end
      end
      PH_DATA: begin
        data_sum_next    = sum_add;
        res_valid        = 1'b1;
        res.payload_byte = b;
        res.last_payload = last_data;
        if (last_data) begin
          phase_next = PH_DCS;
        end
      end
      PH_DCS: begin
        data_sum_next = sum_add;
        if (sum_add != 8'd0) begin
          res_valid        = 1'b1;
          res.is_status    = 1'b1;
          res.frame_status = ST_DATA_SUM;
        end else begin
          phase_next = PH_POST;
        end
      end
      PH_POST: begin
        res_valid        = 1'b1;
        res.is_status    = 1'b1;
        res.frame_status = (b == ZeroByte) ? ST_OK : ST_POSTAMBLE;
      end
      default: begin
        // Idle without a start: the byte is dropped and nothing moves.
        phase_next         = PH_IDLE;
        byte_position_next = cur_pos;
      end
    endcase
    // Every status result closes the frame.
    if (res.is_status) begin
      phase_next         = PH_IDLE;
      byte_position_next = cur_pos;
    end
  end

  // Parser state registers, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= 9'd0;
      data_sum      <= 8'd0;
      length_byte   <= 8'd0;
      frame_empty   <= 1'b0;
    end else if (in_fire) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      data_sum      <= data_sum_next;
      length_byte   <= length_byte_next;
      frame_empty   <= frame_empty_next;
    end
  end

  // A status result leaves the parser idle.
  `RRFD_ASSERT_NEXT(a_status_idles, in_fire && res_valid && res.is_status, phase == PH_IDLE, "status result did not return the parser to idle")
  // Payload bytes come only from the data phase of a running frame.
  `RRFD_ASSERT_NOW(a_payload_phase, res_valid && !res.is_status, (phase == PH_DATA) && !in_item.frame_start, "payload result outside the data phase")
  // The last payload byte is the one the length field points at.
  `RRFD_ASSERT_NEXT(a_last_closes, in_fire && res_valid && res.last_payload, phase == PH_DCS, "last payload byte did not move the parser to the checksum byte")

endmodule

// File: rtl/core/rrfd_out_stage.sv
// Result register between the parser and the output channel.
// Depends on rrfd_pkg for the result type.
`timescale 1ns / 1ps

module rrfd_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_load,
  input  rrfd_pkg::out_t res,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output rrfd_pkg::out_t out_item
);
  import rrfd_pkg::*;

  // The slot is blocked only while a held result is stalled.
  assign busy = out_valid && out_stall;

  // Result register: refilled whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!busy) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && res_load) begin
      out_item <= res;
    end
  end

endmodule

// File: rtl/core/reader_response_frame_deframer_top.sv
// Reader response frame deframer: byte-wise parser of reader response frames.
// Uses a stalled-valid input and output channel and an APB-style
// configuration port holding the expected command code at address 0.
// One received byte is a request on the input channel (rx_byte, frame_start).
// frame_start restarts the parser on the first preamble byte of a frame.
// Each request yields zero or one result: a payload byte (is_status low,
// last_payload marking the final one) or the single end-of-frame status.
// Each result is registered onto out_valid in the cycle after its request.
// Throughput is one request per cycle; the per-byte compare and add sit
// between the parser state registers and a single result register.
// When the receiver stalls a held result, in_stall rises and the input
// waits until that result is taken; an unstalled output never blocks.
// Reset (rst, synchronous) clears the command register to zero, returns the
// parser to idle and empties the result register. Bytes received while idle
// without frame_start are dropped, and bytes after a status are ignored.
// Write the command register only while no frame is in flight.
`timescale 1ns / 1ps

module reader_response_frame_deframer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rrfd_pkg::in_t              in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rrfd_pkg::out_t             out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rrfd_pkg::AddrW-1:0] paddr,
  input  logic [rrfd_pkg::DataW-1:0] pwdata,
  output logic [rrfd_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import rrfd_pkg::*;

  logic       in_fire;
  logic       res_valid;
  out_t       res;
  logic       busy;
  logic [7:0] expected_command;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  // Configuration registers.
  rrfd_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .expected_command (expected_command)
  );

  // Byte parser.
  rrfd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .expected_command (expected_command),
    .in_fire          (in_fire),
    .in_item          (in_item),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Result register.
  rrfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (in_fire && res_valid),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
